/* rtl/core/blstack_pkg.sv */
// Shared constants and types for the bounded LIFO stack with search.
package blstack_pkg;

   localparam int DEPTH   = 64;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = 7;
   localparam int CMD_W   = 3;
   localparam int STAT_W  = 3;
   localparam int DATA_W  = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_PEEK   = 3'd2,
      CMD_SEARCH = 3'd3,
      CMD_DUMP   = 3'd4
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_FULL      = 3'd1,
      STAT_EMPTY     = 3'd2,
      STAT_FOUND     = 3'd3,
      STAT_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TOP,
      ST_SCAN,
      ST_DUMP_RD,
      ST_RESP
   } state_type;

endpackage

/* rtl/core/bounded_lifo_stack_with_search.sv */
// Bounded LIFO stack with search and dump, built around one memory port and a sequencer.
//
//   channel | direction | handshake        | payload
//   req     | in        | req_valid/ready  | req_command, req_data_value
//   rsp     | out       | rsp_valid/ready  | rsp_status, rsp_result_value,
//           |           |                  | rsp_entry_count, rsp_last
//
// Push and every error go straight to the result; pop and peek make one memory read first.
// Search reads one entry per cycle from the top down and stops at a match or at the bottom.
// Dump reads entry after entry from the top down, and the next read waits until the consumer
// takes the last word. Reset is synchronous and empties the stack.
// A stalled result holds the block, and no request word is taken until it leaves.
module bounded_lifo_stack_with_search (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [blstack_pkg::CMD_W-1:0]       req_command,
   input  logic signed [blstack_pkg::DATA_W-1:0] req_data_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [blstack_pkg::STAT_W-1:0]      rsp_status,
   output logic signed [blstack_pkg::DATA_W-1:0] rsp_result_value,
   output logic [blstack_pkg::COUNT_W-1:0]     rsp_entry_count,
   output logic                                rsp_last
);

   blstack_pkg::state_type              state_ff, state_in;
   logic [blstack_pkg::COUNT_W-1:0]     fill_ff, fill_in;
   logic [blstack_pkg::ADDR_W-1:0]      idx_ff, idx_in;
   logic [blstack_pkg::CMD_W-1:0]       cmd_ff, cmd_in;
   logic signed [blstack_pkg::DATA_W-1:0] key_ff, key_in;

   blstack_pkg::status_type             status_ff, status_in;
   logic signed [blstack_pkg::DATA_W-1:0] value_ff, value_in;
   logic [blstack_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic                                last_ff, last_in;

   logic signed [blstack_pkg::DATA_W-1:0] mem [blstack_pkg::DEPTH];
   logic signed [blstack_pkg::DATA_W-1:0] rd_data_ff;
   logic [blstack_pkg::ADDR_W-1:0]      mem_addr;
   logic                                mem_we;

   logic [blstack_pkg::COUNT_W-1:0]     fill_dec;
   logic                                is_full;
   logic                                is_empty;

   assign fill_dec = fill_ff - blstack_pkg::COUNT_W'(1);
   assign is_full  = (fill_ff >= blstack_pkg::COUNT_W'(blstack_pkg::DEPTH));
   assign is_empty = (fill_ff == '0);

   // Single-port store: one write or one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= req_data_value;
      end
      rd_data_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= blstack_pkg::ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
      idx_ff    <= idx_in;
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      count_ff  <= count_in;
      last_ff   <= last_in;
   end

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      status_in = status_ff;
      value_in  = value_ff;
      count_in  = count_ff;
      last_in   = last_ff;
      mem_addr  = idx_ff;
      mem_we    = 1'b0;
      req_ready = (state_ff == blstack_pkg::ST_IDLE);

      case (state_ff)
         blstack_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_command;
               key_in   = req_data_value;
               value_in = '0;
               last_in  = 1'b1;
               count_in = fill_ff;
               case (req_command)
                  blstack_pkg::CMD_PUSH: begin
                     state_in = blstack_pkg::ST_RESP;
                     if (is_full) begin
                        status_in = blstack_pkg::STAT_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_addr  = fill_ff[blstack_pkg::ADDR_W-1:0];
                        fill_in   = fill_ff + blstack_pkg::COUNT_W'(1);
                        count_in  = fill_ff + blstack_pkg::COUNT_W'(1);
                        status_in = blstack_pkg::STAT_OK;
                     end
                  end
                  blstack_pkg::CMD_POP, blstack_pkg::CMD_PEEK,
                  blstack_pkg::CMD_SEARCH, blstack_pkg::CMD_DUMP: begin
                     if (is_empty) begin
                        status_in = blstack_pkg::STAT_EMPTY;
                        state_in  = blstack_pkg::ST_RESP;
                     end else begin
                        // Start the read of the top entry right away.
                        idx_in   = fill_dec[blstack_pkg::ADDR_W-1:0];
                        mem_addr = fill_dec[blstack_pkg::ADDR_W-1:0];
                        if (req_command == blstack_pkg::CMD_SEARCH) begin
                           state_in = blstack_pkg::ST_SCAN;
                        end else if (req_command == blstack_pkg::CMD_DUMP) begin
                           state_in = blstack_pkg::ST_DUMP_RD;
                        end else begin
                           state_in = blstack_pkg::ST_TOP;
                        end
                     end
                  end
                  default: begin
                     // Unknown commands are dropped without a result.
                     state_in = blstack_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         blstack_pkg::ST_TOP: begin
            status_in = blstack_pkg::STAT_OK;
            value_in  = rd_data_ff;
            state_in  = blstack_pkg::ST_RESP;
            if (cmd_ff == blstack_pkg::CMD_POP) begin
               fill_in  = fill_dec;
               count_in = fill_dec;
            end else begin
               count_in = fill_ff;
            end
         end
         blstack_pkg::ST_SCAN: begin
            // The read data holds the entry at idx_ff; the next read is issued meanwhile.
            if (rd_data_ff == key_ff) begin
               status_in = blstack_pkg::STAT_FOUND;
               state_in  = blstack_pkg::ST_RESP;
            end else if (idx_ff == '0) begin
               status_in = blstack_pkg::STAT_NOT_FOUND;
               state_in  = blstack_pkg::ST_RESP;
            end else begin
               idx_in   = idx_ff - blstack_pkg::ADDR_W'(1);
               mem_addr = idx_ff - blstack_pkg::ADDR_W'(1);
            end
         end
         blstack_pkg::ST_DUMP_RD: begin
            status_in = blstack_pkg::STAT_OK;
            value_in  = rd_data_ff;
            count_in  = fill_ff;
            last_in   = (idx_ff == '0);
            state_in  = blstack_pkg::ST_RESP;
         end
         blstack_pkg::ST_RESP: begin
            if (rsp_ready) begin
               if (cmd_ff == blstack_pkg::CMD_DUMP && !last_ff) begin
                  idx_in   = idx_ff - blstack_pkg::ADDR_W'(1);
                  mem_addr = idx_ff - blstack_pkg::ADDR_W'(1);
                  state_in = blstack_pkg::ST_DUMP_RD;
               end else begin
                  state_in = blstack_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = blstack_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid        = (state_ff == blstack_pkg::ST_RESP);
   assign rsp_status       = status_ff;
   assign rsp_result_value = value_ff;
   assign rsp_entry_count  = count_ff;
   assign rsp_last         = last_ff;

endmodule

/* test/tb_bounded_lifo_stack_with_search.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the bounded LIFO stack with search and dump.
module tb_bounded_lifo_stack_with_search;

   typedef logic signed [blstack_pkg::DATA_W-1:0] word_type;

   typedef struct {
      blstack_pkg::status_type           status;
      word_type                          value;
      logic [blstack_pkg::COUNT_W-1:0]   count;
      logic                              last;
   } rsp_word_type;

   // Command codes 5 to 7 have no meaning; the block ignores them.
   localparam logic [blstack_pkg::CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;

   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIX   = 2;

   // Shadow copy of the stack and the result words it owes.
   class stack_shadow;
      word_type     entries [blstack_pkg::DEPTH];
      int           level;
      rsp_word_type pending_words [$];
      int           error_count;

      function new();
         level = 0;
         error_count = 0;
      endfunction

      function void add_word(blstack_pkg::status_type status, word_type value, logic last);
         rsp_word_type w;
         w.status = status;
         w.value = value;
         w.count = blstack_pkg::COUNT_W'(level);
         w.last = last;
         pending_words.push_back(w);
      endfunction

      function void note_request(logic [blstack_pkg::CMD_W-1:0] cmd, word_type val);
         bit hit;
         hit = 1'b0;
         case (cmd)
            blstack_pkg::CMD_PUSH: begin
               if (level >= blstack_pkg::DEPTH) begin
                  add_word(blstack_pkg::STAT_FULL, '0, 1'b1);
               end else begin
                  entries[level] = val;
                  level++;
                  add_word(blstack_pkg::STAT_OK, '0, 1'b1);
               end
            end
            blstack_pkg::CMD_POP: begin
               if (level == 0) begin
                  add_word(blstack_pkg::STAT_EMPTY, '0, 1'b1);
               end else begin
                  level--;
                  add_word(blstack_pkg::STAT_OK, entries[level], 1'b1);
               end
            end
            blstack_pkg::CMD_PEEK: begin
               if (level == 0) begin
                  add_word(blstack_pkg::STAT_EMPTY, '0, 1'b1);
               end else begin
                  add_word(blstack_pkg::STAT_OK, entries[level - 1], 1'b1);
               end
            end
            blstack_pkg::CMD_SEARCH: begin
               if (level == 0) begin
                  add_word(blstack_pkg::STAT_EMPTY, '0, 1'b1);
               end else begin
                  for (int i = level; i > 0; i--) begin
                     if (entries[i - 1] == val) begin
                        hit = 1'b1;
                     end
                  end
                  if (hit) begin
                     add_word(blstack_pkg::STAT_FOUND, '0, 1'b1);
                  end else begin
                     add_word(blstack_pkg::STAT_NOT_FOUND, '0, 1'b1);
                  end
               end
            end
            blstack_pkg::CMD_DUMP: begin
               if (level == 0) begin
                  add_word(blstack_pkg::STAT_EMPTY, '0, 1'b1);
               end else begin
                  for (int i = level; i > 0; i--) begin
                     add_word(blstack_pkg::STAT_OK, entries[i - 1], i == 1);
                  end
               end
            end
            default: begin
            end
         endcase
      endfunction

      function void compare_field(string name, logic signed [63:0] exp,
                                  logic signed [63:0] act);
         if (exp !== act) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp, act);
         end
      endfunction

      function void check_word(logic [blstack_pkg::STAT_W-1:0] status, word_type value,
                               logic [blstack_pkg::COUNT_W-1:0] count, logic last);
         rsp_word_type w;
         if (pending_words.size() == 0) begin
            error_count++;
            $display("%0t: result word with none expected, expected nothing, %s",
                     $time, "actual:");
            $display("   %0d %0d %0d %0b", status, value, count, last);
            return;
         end
         w = pending_words.pop_front();
         compare_field("status", w.status, status);
         compare_field("result_value", w.value, value);
         compare_field("entry_count", w.count, count);
         compare_field("last", w.last, last);
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [blstack_pkg::CMD_W-1:0]     req_command;
   word_type                          req_data_value;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [blstack_pkg::STAT_W-1:0]    rsp_status;
   word_type                          rsp_result_value;
   logic [blstack_pkg::COUNT_W-1:0]   rsp_entry_count;
   logic                              rsp_last;

   stack_shadow shadow = new();
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          items_sent = 0;

   bounded_lifo_stack_with_search i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_data_value   (req_data_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_last         (rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Partly small values and extremes so that searches hit and duplicates occur.
   function automatic word_type pick_value();
      word_type extreme_vals [4] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1};
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 30) begin
         return word_type'($urandom_range(15));
      end else if (sel < 42) begin
         return extreme_vals[$urandom_range(3)];
      end
      return word_type'($urandom);
   endfunction

   function automatic word_type search_value();
      if (shadow.level > 0 && $urandom_range(1) == 1) begin
         return shadow.entries[$urandom_range(shadow.level - 1)];
      end
      return pick_value();
   endfunction

   function automatic logic [blstack_pkg::CMD_W-1:0] random_command(int mode);
      int unsigned sel;
      sel = $urandom_range(99);
      case (mode)
         MODE_FILL: begin
            if (sel < 80) return blstack_pkg::CMD_PUSH;
            if (sel < 86) return blstack_pkg::CMD_POP;
            if (sel < 90) return blstack_pkg::CMD_PEEK;
            if (sel < 96) return blstack_pkg::CMD_SEARCH;
            return blstack_pkg::CMD_DUMP;
         end
         MODE_DRAIN: begin
            if (sel < 15) return blstack_pkg::CMD_PUSH;
            if (sel < 75) return blstack_pkg::CMD_POP;
            if (sel < 83) return blstack_pkg::CMD_PEEK;
            if (sel < 93) return blstack_pkg::CMD_SEARCH;
            return blstack_pkg::CMD_DUMP;
         end
         default: begin
            if (sel < 30) return blstack_pkg::CMD_PUSH;
            if (sel < 55) return blstack_pkg::CMD_POP;
            if (sel < 67) return blstack_pkg::CMD_PEEK;
            if (sel < 85) return blstack_pkg::CMD_SEARCH;
            if (sel < 93) return blstack_pkg::CMD_DUMP;
            return CMD_FIRST_UNUSED + blstack_pkg::CMD_W'($urandom_range(2));
         end
      endcase
   endfunction

   // Offers one request word and returns once it has been taken.
   task automatic send_word(logic [blstack_pkg::CMD_W-1:0] cmd, word_type val);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_data_value <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      shadow.note_request(cmd, val);
      if (cmd < CMD_FIRST_UNUSED) begin
         items_sent++;
      end
   endtask

   // Pushes until the stack is full, then exercises the full-stack cases.
   task automatic fill_to_full();
      while (shadow.level < blstack_pkg::DEPTH) send_word(blstack_pkg::CMD_PUSH, pick_value());
      send_word(blstack_pkg::CMD_PUSH, pick_value());
      send_word(blstack_pkg::CMD_PUSH, pick_value());
      send_word(blstack_pkg::CMD_DUMP, pick_value());
      send_word(blstack_pkg::CMD_SEARCH, shadow.entries[0]);
      send_word(blstack_pkg::CMD_SEARCH, pick_value());
   endtask

   task automatic run_phase(int idle, int stall, bit with_fill, int target);
      int                              mode;
      int                              len;
      logic [blstack_pkg::CMD_W-1:0]   cmd;
      send_idle_pct = idle;
      stall_pct = stall;
      if (with_fill) begin
         fill_to_full();
      end
      while (items_sent < target) begin
         mode = $urandom_range(MODE_MIX);
         len = $urandom_range(30, 8);
         for (int k = 0; k < len; k++) begin
            cmd = random_command(mode);
            if (cmd == blstack_pkg::CMD_SEARCH) begin
               send_word(cmd, search_value());
            end else begin
               send_word(cmd, pick_value());
            end
         end
      end
   endtask

   // Result side: checks every accepted word and stalls at random.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            shadow.check_word(rsp_status, rsp_result_value, rsp_entry_count, rsp_last);
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_command <= blstack_pkg::CMD_PUSH;
      req_data_value <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Empty-stack errors, ignored codes, extreme values and short dumps.
      send_word(blstack_pkg::CMD_PEEK, '0);
      send_word(blstack_pkg::CMD_POP, 32'sh7FFF_FFFF);
      send_word(blstack_pkg::CMD_SEARCH, '0);
      send_word(blstack_pkg::CMD_DUMP, '1);
      send_word(CMD_FIRST_UNUSED, '1);
      send_word(blstack_pkg::CMD_PUSH, 32'sh8000_0000);
      send_word(blstack_pkg::CMD_PUSH, 32'sh7FFF_FFFF);
      send_word(blstack_pkg::CMD_PUSH, '0);
      send_word(blstack_pkg::CMD_PUSH, '1);
      send_word(blstack_pkg::CMD_PEEK, 32'sh5555_5555);
      send_word(blstack_pkg::CMD_SEARCH, 32'sh8000_0000);
      send_word(blstack_pkg::CMD_SEARCH, 32'sd12345);
      send_word(blstack_pkg::CMD_SEARCH, '1);
      send_word(blstack_pkg::CMD_DUMP, 32'shAAAA_AAAA);
      send_word(CMD_FIRST_UNUSED + 3'd1, 32'sh5A5A_A5A5);
      send_word(CMD_FIRST_UNUSED + 3'd2, '0);
      send_word(blstack_pkg::CMD_POP, '0);
      send_word(blstack_pkg::CMD_POP, '1);
      send_word(blstack_pkg::CMD_PEEK, '0);
      send_word(blstack_pkg::CMD_POP, '0);
      send_word(blstack_pkg::CMD_POP, '0);
      send_word(blstack_pkg::CMD_POP, '0);
      send_word(blstack_pkg::CMD_DUMP, '0);

      run_phase(0, 0, 1'b1, 95);
      run_phase(81, 0, 1'b0, 190);
      run_phase(0, 81, 1'b1, 285);
      run_phase(36, 36, 1'b0, 380);
      req_valid <= 1'b0;

      while (shadow.pending_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (shadow.error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

/* bounded_lifo_stack_with_search.f */
rtl/core/blstack_pkg.sv
rtl/core/bounded_lifo_stack_with_search.sv
test/tb_bounded_lifo_stack_with_search.sv
